/* rtl/atrp_pkg.sv */
`timescale 1ns / 1ps

package atrp_pkg;

    localparam int BUFFER_BYTES_DEF = 128;
    localparam int NUM_FIELDS       = 7;
    localparam int QUEUE_DEPTH      = 3;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    localparam logic [1:0] EV_RECORD   = 2'd0;
    localparam logic [1:0] EV_END      = 2'd1;
    localparam logic [1:0] EV_SLASH    = 2'd2;
    localparam logic [1:0] EV_OVERFLOW = 2'd3;

    localparam logic [1:0] SLOT_NONE  = 2'd0;
    localparam logic [1:0] SLOT_ONE   = 2'd1;
    localparam logic [1:0] SLOT_TWO   = 2'd2;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic [1:0] event_code;
        logic [1:0] slot_index;
        t_byte      task_count;
        t_byte      task_ident;
        t_byte      start_x;
        t_byte      start_y;
        t_byte      start_z;
        t_byte      end_x;
        t_byte      end_y;
        t_byte      end_z;
        logic       last_of_run;
    } t_result;

    // Two ASCII digits to a value, wrapped to eight bits and not checked.
    function automatic t_byte decode_pair(input t_byte hi, input t_byte lo);
        t_byte h;
        t_byte l;
        h = hi - CH_ZERO;
        l = lo - CH_ZERO;
        return t_byte'({h, 3'b000} + {h, 1'b0} + l);
    endfunction

endpackage

/* rtl/ascii_task_record_parser.sv */
`timescale 1ns / 1ps

// A result is written into the registered result queue when the byte that caused it is transferred.
// Throughput: one byte per cycle while input ready is high; a byte that yields two results may hold input ready
// low while the three-entry result queue drains.
// Input ready is high while the result queue holds at most one result.
// Reset (synchronous, active low) clears the frame state and empties the result queue.
module ascii_task_record_parser #(
    parameter int BUFFER_BYTES = atrp_pkg::BUFFER_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  atrp_pkg::t_byte     i_frame_byte,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [1:0]          o_event_code,
    output logic [1:0]          o_slot_index,
    output atrp_pkg::t_byte     o_task_count,
    output atrp_pkg::t_byte     o_task_ident,
    output atrp_pkg::t_byte     o_start_x,
    output atrp_pkg::t_byte     o_start_y,
    output atrp_pkg::t_byte     o_start_z,
    output atrp_pkg::t_byte     o_end_x,
    output atrp_pkg::t_byte     o_end_y,
    output atrp_pkg::t_byte     o_end_z,
    output logic                o_last_of_run
);
    import atrp_pkg::*;

    localparam int PW = $clog2(BUFFER_BYTES);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [PW-1:0] r_pos;
    logic [PW-1:0] n_pos;
    logic [1:0]    r_mod3;
    logic [1:0]    n_mod3;
    logic [PW-1:0] r_grp;
    logic [PW-1:0] n_grp;
    logic [2:0]    r_grp7;
    logic [2:0]    n_grp7;
    t_byte         r_tens;
    t_byte         n_tens;
    t_byte         r_count;
    t_byte         n_count;
    t_byte         r_fields [NUM_FIELDS];
    t_byte         n_fields [NUM_FIELDS];

    t_result       r_q [QUEUE_DEPTH];
    t_result       n_q [QUEUE_DEPTH];
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;

    logic          accept;
    logic          pop;
    logic          emit;
    logic          term;
    logic [1:0]    term_code;
    logic [1:0]    slot;
    t_byte         value;
    t_result       res_rec;
    t_result       res_term;
    t_result       res_a;
    t_result       res_b;
    logic [CW-1:0] base;

    assign accept = i_valid && o_ready;
    assign pop    = o_valid && i_ready;

    assign value = decode_pair(r_tens, i_frame_byte);

    always_comb begin
        if (r_grp >= PW'(8) && r_grp <= PW'(14)) begin
            slot = SLOT_ONE;
        end else if (r_grp >= PW'(15) && r_grp <= PW'(21)) begin
            slot = SLOT_TWO;
        end else begin
            slot = SLOT_NONE;
        end
    end

    always_comb begin
        n_pos     = r_pos;
        n_mod3    = r_mod3;
        n_grp     = r_grp;
        n_grp7    = r_grp7;
        n_tens    = r_tens;
        n_count   = r_count;
        n_fields  = r_fields;
        emit      = 1'b0;
        term      = 1'b0;
        term_code = EV_END;

        if (r_pos == '0) begin
            n_tens = i_frame_byte;
        end else if (r_pos == PW'(1)) begin
            n_count = value;
            n_tens  = i_frame_byte;
        end else begin
            if (r_mod3 == 2'd1 && r_grp != '0) begin
                if (r_grp7 == 3'd0) begin
                    n_fields[NUM_FIELDS-1] = value;
                    emit = 1'b1;
                end else begin
                    n_fields[r_grp7 - 3'd1] = value;
                end
            end
            if (i_frame_byte == CH_HASH) begin
                term      = 1'b1;
                term_code = EV_END;
            end else if (i_frame_byte == CH_SLASH && r_mod3 != 2'd2) begin
                term      = 1'b1;
                term_code = EV_SLASH;
            end else begin
                n_tens = i_frame_byte;
            end
        end

        if (!term) begin
            if (r_pos == PW'(BUFFER_BYTES - 1)) begin
                term      = 1'b1;
                term_code = EV_OVERFLOW;
            end else begin
                n_pos = r_pos + PW'(1);
                if (r_mod3 == 2'd2) begin
                    n_mod3 = 2'd0;
                    n_grp  = r_grp + PW'(1);
                    n_grp7 = (r_grp7 == 3'd6) ? 3'd0 : r_grp7 + 3'd1;
                end else begin
                    n_mod3 = r_mod3 + 2'd1;
                end
            end
        end

        if (term) begin
            n_pos   = '0;
            n_mod3  = 2'd0;
            n_grp   = '0;
            n_grp7  = 3'd0;
            n_tens  = '0;
            n_count = '0;
            for (int i = 0; i < NUM_FIELDS; i++) begin
                n_fields[i] = '0;
            end
        end
    end

    always_comb begin
        res_rec             = '0;
        res_rec.event_code  = EV_RECORD;
        res_rec.slot_index  = slot;
        res_rec.task_count  = r_count;
        res_rec.task_ident  = r_fields[0];
        res_rec.start_x     = r_fields[1];
        res_rec.start_y     = r_fields[2];
        res_rec.start_z     = r_fields[3];
        res_rec.end_x       = r_fields[4];
        res_rec.end_y       = r_fields[5];
        res_rec.end_z       = value;
        res_rec.last_of_run = !term;

        res_term             = '0;
        res_term.event_code  = term_code;
        res_term.slot_index  = SLOT_NONE;
        res_term.task_count  = r_count;
        res_term.last_of_run = 1'b1;

        res_a = emit ? res_rec : res_term;
        res_b = res_term;
    end

    always_comb begin
        n_q   = r_q;
        n_cnt = r_cnt;
        if (pop) begin
            for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
                n_q[k] = r_q[k+1];
            end
            n_cnt = r_cnt - CW'(1);
        end
        base = n_cnt;
        if (accept) begin
            for (int k = 0; k < QUEUE_DEPTH; k++) begin
                if ((emit || term) && base == CW'(k)) begin
                    n_q[k] = res_a;
                end
                if (emit && term && base + CW'(1) == CW'(k)) begin
                    n_q[k] = res_b;
                end
            end
            n_cnt = base + CW'(emit) + CW'(term);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_mod3  <= 2'd0;
            r_grp   <= '0;
            r_grp7  <= 3'd0;
            r_tens  <= '0;
            r_count <= '0;
            r_cnt   <= '0;
            for (int i = 0; i < NUM_FIELDS; i++) begin
                r_fields[i] <= '0;
            end
        end else begin
            r_cnt <= n_cnt;
            if (accept) begin
                r_pos    <= n_pos;
                r_mod3   <= n_mod3;
                r_grp    <= n_grp;
                r_grp7   <= n_grp7;
                r_tens   <= n_tens;
                r_count  <= n_count;
                r_fields <= n_fields;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_ready       = (r_cnt <= CW'(1));
    assign o_valid       = (r_cnt != '0);
    assign o_event_code  = r_q[0].event_code;
    assign o_slot_index  = r_q[0].slot_index;
    assign o_task_count  = r_q[0].task_count;
    assign o_task_ident  = r_q[0].task_ident;
    assign o_start_x     = r_q[0].start_x;
    assign o_start_y     = r_q[0].start_y;
    assign o_start_z     = r_q[0].start_z;
    assign o_end_x       = r_q[0].end_x;
    assign o_end_y       = r_q[0].end_y;
    assign o_end_z       = r_q[0].end_z;
    assign o_last_of_run = r_q[0].last_of_run;

endmodule

/* sim/tb_ascii_task_record_parser.sv */
`timescale 1ns / 1ps

class t_record_scoreboard;
    int unsigned       position;
    atrp_pkg::t_byte   tens_digit;
    atrp_pkg::t_byte   decoded_count;
    atrp_pkg::t_byte   field_values[7];
    atrp_pkg::t_result pending_results[$];
    int                buffer_bytes;
    int                errors;
    int                bytes_seen;
    int                records;
    int                frame_ends;
    int                slash_errors;
    int                overflows;

    function new(int buffer_bytes);
        this.buffer_bytes = buffer_bytes;
        clear_frame();
    endfunction

    function void clear_frame();
        position = 0;
        tens_digit = '0;
        decoded_count = '0;
        foreach (field_values[i]) field_values[i] = '0;
    endfunction

    function atrp_pkg::t_byte digit_pair(atrp_pkg::t_byte hi, atrp_pkg::t_byte lo);
        int value;
        value = (int'(hi) - int'(atrp_pkg::CH_ZERO)) * 10 + (int'(lo) - int'(atrp_pkg::CH_ZERO));
        return atrp_pkg::t_byte'(value);
    endfunction

    function logic [1:0] slot_for(int unsigned tens_pos);
        int unsigned group;
        group = tens_pos / 3;
        if (group >= 8 && group < 15) return atrp_pkg::SLOT_ONE;
        if (group >= 15 && group < 22) return atrp_pkg::SLOT_TWO;
        return atrp_pkg::SLOT_NONE;
    endfunction

    function atrp_pkg::t_result make_result(logic [1:0] code, logic [1:0] slot, bit with_fields);
        atrp_pkg::t_result res;
        res.event_code = code;
        res.slot_index = slot;
        res.task_count = decoded_count;
        res.task_ident = with_fields ? field_values[0] : '0;
        res.start_x = with_fields ? field_values[1] : '0;
        res.start_y = with_fields ? field_values[2] : '0;
        res.start_z = with_fields ? field_values[3] : '0;
        res.end_x = with_fields ? field_values[4] : '0;
        res.end_y = with_fields ? field_values[5] : '0;
        res.end_z = with_fields ? field_values[6] : '0;
        res.last_of_run = 1'b0;
        return res;
    endfunction

    function void note_frame_byte(atrp_pkg::t_byte b);
        atrp_pkg::t_result batch[$];
        int unsigned pos;
        int unsigned prev;
        int unsigned offset;
        int unsigned idx;
        bit ended;
        pos = position;
        ended = 0;
        bytes_seen++;
        if (pos == 0) begin
            tens_digit = b;
        end else if (pos == 1) begin
            decoded_count = digit_pair(tens_digit, b);
            tens_digit = b;
        end else begin
            prev = pos - 1;
            if (prev >= 3 && prev % 3 == 0) begin
                offset = prev % 21;
                idx = (offset == 0) ? 6 : offset / 3 - 1;
                field_values[idx] = digit_pair(tens_digit, b);
                if (idx == 6) begin
                    batch.push_back(make_result(atrp_pkg::EV_RECORD, slot_for(prev), 1));
                    records++;
                end
            end
            if (b == atrp_pkg::CH_HASH) begin
                batch.push_back(make_result(atrp_pkg::EV_END, atrp_pkg::SLOT_NONE, 0));
                frame_ends++;
                ended = 1;
            end else if (b == atrp_pkg::CH_SLASH && pos % 3 != 2) begin
                batch.push_back(make_result(atrp_pkg::EV_SLASH, atrp_pkg::SLOT_NONE, 0));
                slash_errors++;
                ended = 1;
            end else begin
                tens_digit = b;
            end
        end
        if (!ended) begin
            pos++;
            if (pos >= buffer_bytes) begin
                batch.push_back(make_result(atrp_pkg::EV_OVERFLOW, atrp_pkg::SLOT_NONE, 0));
                overflows++;
                ended = 1;
            end else begin
                position = pos;
            end
        end
        if (ended) clear_frame();
        if (batch.size() > 0) batch[batch.size() - 1].last_of_run = 1'b1;
        foreach (batch[i]) pending_results.push_back(batch[i]);
    endfunction

    function void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function void check_result(atrp_pkg::t_result got);
        atrp_pkg::t_result want;
        if (pending_results.size() == 0) begin
            $error("result transfer with no result expected (event_code %0d)", got.event_code);
            errors++;
            return;
        end
        want = pending_results.pop_front();
        check_field("event_code", want.event_code, got.event_code);
        check_field("slot_index", want.slot_index, got.slot_index);
        check_field("task_count", want.task_count, got.task_count);
        check_field("task_ident", want.task_ident, got.task_ident);
        check_field("start_x", want.start_x, got.start_x);
        check_field("start_y", want.start_y, got.start_y);
        check_field("start_z", want.start_z, got.start_z);
        check_field("end_x", want.end_x, got.end_x);
        check_field("end_y", want.end_y, got.end_y);
        check_field("end_z", want.end_z, got.end_z);
        check_field("last_of_run", want.last_of_run, got.last_of_run);
    endfunction
endclass

module tb_ascii_task_record_parser;
    import atrp_pkg::*;

    localparam int BUF_BYTES   = BUFFER_BYTES_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int BYTE_TARGET = 1400;

    typedef enum int {
        CLOSE_HASH,
        CLOSE_HASH_AS_DIGIT,
        CLOSE_SLASH_AS_DIGIT,
        CLOSE_CUT
    } t_frame_close;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    t_byte      i_frame_byte;
    logic       o_valid;
    logic       i_ready;
    logic [1:0] o_event_code;
    logic [1:0] o_slot_index;
    t_byte      o_task_count;
    t_byte      o_task_ident;
    t_byte      o_start_x;
    t_byte      o_start_y;
    t_byte      o_start_z;
    t_byte      o_end_x;
    t_byte      o_end_y;
    t_byte      o_end_z;
    logic       o_last_of_run;

    t_record_scoreboard sb;
    int                 cycles;
    int                 burst_left;
    int                 stall_mode;
    int                 stall_left;
    t_byte              directed_bytes[$];

    ascii_task_record_parser #(
        .BUFFER_BYTES(BUF_BYTES)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_frame_byte (i_frame_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_event_code (o_event_code),
        .o_slot_index (o_slot_index),
        .o_task_count (o_task_count),
        .o_task_ident (o_task_ident),
        .o_start_x    (o_start_x),
        .o_start_y    (o_start_y),
        .o_start_z    (o_start_z),
        .o_end_x      (o_end_x),
        .o_end_y      (o_end_y),
        .o_end_z      (o_end_z),
        .o_last_of_run(o_last_of_run)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // The receiver switches between stall patterns in stretches of random length.
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(10, 60);
        end
        stall_left--;
        case (stall_mode)
            0: i_ready = 1'b1;
            1: i_ready = ($urandom_range(0, 3) != 0);
            2: i_ready = ($urandom_range(0, 3) == 0);
            default: i_ready = (cycles % 4 == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result('{
                event_code: o_event_code, slot_index: o_slot_index,
                task_count: o_task_count, task_ident: o_task_ident,
                start_x: o_start_x, start_y: o_start_y, start_z: o_start_z,
                end_x: o_end_x, end_y: o_end_y, end_z: o_end_z,
                last_of_run: o_last_of_run});
        end
    end

    task automatic send_byte(t_byte b);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                i_valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        @(negedge i_clk);
        i_valid = 1'b1;
        i_frame_byte = b;
        do @(posedge i_clk); while (!o_ready);
        sb.note_frame_byte(b);
        burst_left--;
    endtask

    function automatic t_byte pick_digit();
        t_byte b;
        if ($urandom_range(0, 7) != 0) return CH_ZERO + t_byte'($urandom_range(0, 9));
        do b = t_byte'($urandom_range(0, 255)); while (b == CH_HASH || b == CH_SLASH);
        return b;
    endfunction

    function automatic t_byte pick_separator();
        if ($urandom_range(0, 19) == 0) return pick_digit();
        return CH_SLASH;
    endfunction

    task automatic close_frame();
        if (sb.position == 1) send_byte(CH_ZERO);
        if (sb.position != 0) send_byte(CH_HASH);
    endtask

    task automatic send_record_frame();
        t_byte        frame_bytes[$];
        int           n_records;
        int           cut;
        t_frame_close closing;
        n_records = ($urandom_range(0, 3) == 0) ? 6 : $urandom_range(0, 5);
        frame_bytes.push_back(pick_digit());
        frame_bytes.push_back(pick_digit());
        frame_bytes.push_back(pick_separator());
        for (int k = 0; k < n_records; k++) begin
            for (int j = 0; j < 7; j++) begin
                frame_bytes.push_back(pick_digit());
                frame_bytes.push_back(pick_digit());
                frame_bytes.push_back(pick_separator());
            end
        end
        if (n_records == 0) closing = CLOSE_HASH;
        else if (n_records == 6 && $urandom_range(0, 4) < 3) closing = CLOSE_HASH;
        else closing = t_frame_close'($urandom_range(0, 3));
        case (closing)
            CLOSE_HASH: begin
                frame_bytes.push_back(CH_HASH);
            end
            CLOSE_HASH_AS_DIGIT: begin
                void'(frame_bytes.pop_back());
                frame_bytes[frame_bytes.size() - 1] = CH_HASH;
            end
            CLOSE_SLASH_AS_DIGIT: begin
                void'(frame_bytes.pop_back());
                frame_bytes[frame_bytes.size() - 1] = CH_SLASH;
            end
            default: begin
                cut = $urandom_range(3, frame_bytes.size() - 1);
                while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
                frame_bytes.push_back($urandom_range(0, 1) ? CH_HASH : CH_SLASH);
            end
        endcase
        for (int i = 0; i < frame_bytes.size(); i++) begin
            send_byte(frame_bytes[i]);
            if (sb.position == 0) break;
        end
        close_frame();
    endtask

    task automatic send_noise();
        int    n_bytes;
        t_byte b;
        n_bytes = $urandom_range(1, 30);
        repeat (n_bytes) begin
            case ($urandom_range(0, 4))
                0, 1: b = t_byte'($urandom_range(0, 255));
                2: b = CH_HASH;
                3: b = CH_SLASH;
                default: b = CH_ZERO + t_byte'($urandom_range(0, 9));
            endcase
            send_byte(b);
        end
        close_frame();
    endtask

    // Digits only, so the frame runs into the end of the buffer.
    task automatic send_run_on();
        repeat (BUF_BYTES) send_byte(pick_digit());
        close_frame();
    endtask

    initial begin
        int sel;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_frame_byte = '0;
        cycles = 0;
        burst_left = 0;
        stall_left = 0;
        stall_mode = 0;
        sb = new(BUF_BYTES);
        directed_bytes = '{
            CH_HASH, CH_HASH, CH_HASH,
            8'h00, 8'hFF, CH_SLASH, CH_SLASH,
            CH_ZERO + 8'd9, CH_ZERO + 8'd9, 8'h78, CH_ZERO + 8'd5, CH_SLASH,
            CH_ZERO, CH_ZERO + 8'd1, CH_SLASH, CH_ZERO + 8'd1, CH_HASH,
            CH_ZERO + 8'd4, CH_ZERO + 8'd2, CH_SLASH, CH_ZERO, CH_ZERO + 8'd7, CH_HASH
        };
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
        close_frame();

        while (sb.bytes_seen < BYTE_TARGET) begin
            sel = $urandom_range(0, 19);
            if (sel < 14) send_record_frame();
            else if (sel < 19) send_noise();
            else send_run_on();
        end

        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d frame bytes; saw %0d records, %0d frame ends,", sb.bytes_seen,
                 sb.records, sb.frame_ends);
        $display("%0d misplaced slash errors and %0d buffer overflows.", sb.slash_errors,
                 sb.overflows);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
